// File: hdl/lcet_pkg.sv
package lcet_pkg;

    // Default sizing of the tree
    localparam int DOMAIN_MAX_DEF  = 1024;
    localparam int TREE_LEVELS_DEF = 11;

    // Fixed field widths
    localparam int DATA_W  = 32;
    localparam int X_W     = 11;
    localparam int COUNT_W = 16;

    // Request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // One node of the store
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] k;
    } node_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // request taken
        logic clr;     // clearing pass, one entry
        logic rd;      // read node at current index
        logic mul;     // evaluate both lines
        logic cmp;     // compare, update node, descend
        logic finish;  // load result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;    // last entry of clearing pass
        logic node_valid;  // node just read holds a line
        logic cont;        // walk goes on to a child
        logic out_free;    // result register can take a result
    } dp_stat_t;

endpackage

// File: hdl/lcet_node_store.sv
module lcet_node_store import lcet_pkg::*; #(
    parameter int ADDR_W = TREE_LEVELS_DEF
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  node_t             wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output node_t             rdata
);

    node_t store_mem [(1 << ADDR_W)];
    node_t rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/lcet_ctrl.sv
module lcet_ctrl import lcet_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t state_reg;

    assign s_ready = (state_reg == ST_IDLE);

    // Command decode
    always_comb begin
        cmd        = '0;
        cmd.load   = s_valid && (state_reg == ST_IDLE);
        cmd.clr    = (state_reg == ST_CLEAR);
        cmd.rd     = (state_reg == ST_READ);
        cmd.mul    = (state_reg == ST_MUL);
        cmd.cmp    = (state_reg == ST_CMP);
        cmd.finish = (state_reg == ST_DONE) && stat.out_free;
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (stat.clr_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= stat.node_valid ? ST_CMP : ST_DONE;
                end
                ST_CMP: begin
                    state_reg <= stat.cont ? ST_READ : ST_DONE;
                end
                ST_DONE: begin
                    if (stat.out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // Checks
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.clr, cmd.rd, cmd.mul, cmd.cmp, cmd.finish}))
        else $error("controller issued two commands at once");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> stat.out_free)
        else $error("result loaded while result register busy");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clr_last && cmd.clr |=> !cmd.clr)
        else $error("clearing pass ran past the last entry");

endmodule

// File: hdl/lcet_datapath.sv
module lcet_datapath import lcet_pkg::*; #(
    parameter int DOMAIN_MAX  = DOMAIN_MAX_DEF,
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    input  logic                         s_command,
    input  logic signed [DATA_W-1:0]     s_slope,
    input  logic signed [DATA_W-1:0]     s_intercept,
    input  logic [X_W-1:0]               s_query_x,
    output logic                         mem_we,
    output logic [TREE_LEVELS-1:0]       mem_waddr,
    output node_t                        mem_wdata,
    output logic                         mem_re,
    output logic [TREE_LEVELS-1:0]       mem_raddr,
    input  node_t                        mem_rdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic signed [DATA_W-1:0]     m_best_slope,
    output logic signed [DATA_W-1:0]     m_best_intercept,
    output logic [COUNT_W-1:0]           m_line_count,
    output logic                         m_empty_res
);

    localparam int AW  = TREE_LEVELS;
    localparam int DW  = $clog2(DOMAIN_MAX + 1);
    localparam int PW  = (DW > X_W) ? DW : X_W;
    localparam int PRW = DATA_W + PW + 1;
    localparam int VW  = PRW + 1;
    localparam logic [DW-1:0] DOM_HI = DW'(DOMAIN_MAX);

    // Request and walk state
    logic                     query_reg;
    logic signed [DATA_W-1:0] lm_reg, lk_reg;
    logic [X_W-1:0]           x_reg;
    logic [AW:0]              idx_reg;
    logic [DW-1:0]            lo_reg, hi_reg, mid_reg;
    logic signed [PRW-1:0]    pa_mid_reg, pb_mid_reg, pa_hi_reg, pb_hi_reg;
    logic                     best_valid_reg;
    logic signed [VW-1:0]     best_val_reg;
    logic signed [DATA_W-1:0] best_m_reg, best_k_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [AW-1:0]            clr_cnt_reg;

    // Result register
    logic                     m_valid_reg;
    logic                     found_reg;
    logic signed [DATA_W-1:0] best_slope_reg, best_intercept_reg;
    logic [COUNT_W-1:0]       line_count_reg;
    logic                     empty_reg;

    logic [DW:0]              mid_sum;
    logic [PW-1:0]            pt_mid;
    logic signed [PW:0]       pt_mid_s, pt_hi_s;
    logic signed [PRW-1:0]    p_a_mid, p_b_mid, p_a_hi, p_b_hi;
    logic signed [VW-1:0]     va_mid, vb_mid, va_hi, vb_hi;
    logic                     swap, leaf, go_right, go_right_ins, go_right_q;
    logic [AW:0]              next_idx;
    logic                     in_store;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Evaluation points: midpoint (or query point) and upper end
    assign pt_mid   = query_reg ? PW'(x_reg) : PW'(mid_reg);
    assign pt_mid_s = $signed({1'b0, pt_mid});
    assign pt_hi_s  = $signed({1'b0, PW'(hi_reg)});

    // Four products: carried line (a) and stored node (b)
    assign p_a_mid = PRW'(lm_reg) * PRW'(pt_mid_s);
    assign p_b_mid = PRW'(mem_rdata.m) * PRW'(pt_mid_s);
    assign p_a_hi  = PRW'(lm_reg) * PRW'(pt_hi_s);
    assign p_b_hi  = PRW'(mem_rdata.m) * PRW'(pt_hi_s);

    // Line values from registered products
    assign va_mid = VW'(pa_mid_reg) + VW'(lk_reg);
    assign vb_mid = VW'(pb_mid_reg) + VW'(mem_rdata.k);
    assign va_hi  = VW'(pa_hi_reg) + VW'(lk_reg);
    assign vb_hi  = VW'(pb_hi_reg) + VW'(mem_rdata.k);

    // Insert: winner at midpoint, loser direction by value at upper end
    assign swap         = (va_mid < vb_mid);
    assign go_right_ins = swap ? (vb_hi < va_hi) : (va_hi < vb_hi);
    assign leaf         = (hi_reg - lo_reg) <= DW'(1);
    assign go_right_q   = !(PW'(x_reg) < PW'(mid_reg));
    assign go_right     = query_reg ? go_right_q : go_right_ins;

    assign next_idx = {idx_reg[AW-1:0], go_right};
    assign in_store = !next_idx[AW];

    // Status
    assign stat.clr_last   = &clr_cnt_reg;
    assign stat.node_valid = mem_rdata.valid;
    assign stat.cont       = query_reg ? in_store : (!leaf && in_store);
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Store access
    assign mem_re    = cmd.rd;
    assign mem_raddr = idx_reg[AW-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = '{valid: 1'b1, m: lm_reg, k: lk_reg};
        if (cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (cmd.mul && !query_reg && !mem_rdata.valid) begin
            // empty node takes the carried line
            mem_we = 1'b1;
        end else if (cmd.cmp && !query_reg && swap) begin
            // carried line wins the node
            mem_we = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.load && (s_command == CMD_INSERT) && (count_reg != '1)) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            query_reg      <= (s_command == CMD_QUERY);
            lm_reg         <= s_slope;
            lk_reg         <= s_intercept;
            x_reg          <= s_query_x;
            idx_reg        <= (AW + 1)'(1);
            lo_reg         <= '0;
            hi_reg         <= DOM_HI;
            best_valid_reg <= 1'b0;
        end
        if (cmd.rd) begin
            mid_reg <= mid_sum[DW:1];
        end
        if (cmd.mul) begin
            pa_mid_reg <= p_a_mid;
            pb_mid_reg <= p_b_mid;
            pa_hi_reg  <= p_a_hi;
            pb_hi_reg  <= p_b_hi;
        end
        if (cmd.cmp) begin
            if (query_reg) begin
                // first line met, or strictly lower
                if (!best_valid_reg || (vb_mid < best_val_reg)) begin
                    best_val_reg <= vb_mid;
                    best_m_reg   <= mem_rdata.m;
                    best_k_reg   <= mem_rdata.k;
                end
                best_valid_reg <= 1'b1;
            end else if (swap) begin
                // old node line becomes the loser
                lm_reg <= mem_rdata.m;
                lk_reg <= mem_rdata.k;
            end
            idx_reg <= next_idx;
            if (go_right) begin
                lo_reg <= mid_reg;
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.finish) begin
            found_reg          <= query_reg && best_valid_reg;
            best_slope_reg     <= (query_reg && best_valid_reg) ? best_m_reg : '0;
            best_intercept_reg <= (query_reg && best_valid_reg) ? best_k_reg : '0;
            line_count_reg     <= count_reg;
            empty_reg          <= (count_reg == '0);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = found_reg;
    assign m_best_slope     = best_slope_reg;
    assign m_best_intercept = best_intercept_reg;
    assign m_line_count     = line_count_reg;
    assign m_empty_res      = empty_reg;

    // Checks
    a_found_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_empty_res)
        else $error("query found a line in an empty tree");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && (s_command == CMD_INSERT) && (count_reg != '1)
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert counter did not advance");

    a_walk_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && !cmd.clr |-> !query_reg && mem_wdata.valid)
        else $error("store written outside an insert");

endmodule

// File: hdl/min_line_envelope_tree.sv
// Channel  Direction  Ports
// -------  ---------  ------------------------------------------------------------
// s_       in         s_valid s_ready s_command s_slope s_intercept s_query_x
// m_       out        m_valid m_ready m_found m_best_slope m_best_intercept
//                     m_line_count m_empty_res
//
// Each tree level visited runs a node read, a multiply, and a compare and write;
// a request adds an accept step before the walk and a result step after it.
// After reset a clearing pass writes every entry of the node store before any request.
// A new request is taken while a result waits in the output register; a result
// held on m_ stalls the next one only at its final step.
module min_line_envelope_tree import lcet_pkg::*; #(
    parameter int DOMAIN_MAX  = DOMAIN_MAX_DEF,
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command,
    input  logic signed [DATA_W-1:0] s_slope,
    input  logic signed [DATA_W-1:0] s_intercept,
    input  logic [X_W-1:0]           s_query_x,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output logic signed [DATA_W-1:0] m_best_slope,
    output logic signed [DATA_W-1:0] m_best_intercept,
    output logic [COUNT_W-1:0]       m_line_count,
    output logic                     m_empty_res
);

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic                   mem_we;
    logic                   mem_re;
    logic [TREE_LEVELS-1:0] mem_waddr;
    logic [TREE_LEVELS-1:0] mem_raddr;
    node_t                  mem_wdata;
    node_t                  mem_rdata;

    // Sequencer
    lcet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Evaluation, walk and result registers
    lcet_datapath #(
        .DOMAIN_MAX  (DOMAIN_MAX),
        .TREE_LEVELS (TREE_LEVELS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_command        (s_command),
        .s_slope          (s_slope),
        .s_intercept      (s_intercept),
        .s_query_x        (s_query_x),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_re           (mem_re),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_best_slope     (m_best_slope),
        .m_best_intercept (m_best_intercept),
        .m_line_count     (m_line_count),
        .m_empty_res      (m_empty_res)
    );

    // Node store
    lcet_node_store #(
        .ADDR_W (TREE_LEVELS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
